>>> hdl/sorted_union_of_two_sets_top_defines.svh
// assertion macros used by the port checker
`ifndef SORTED_UNION_OF_TWO_SETS_TOP_DEFINES_SVH
`define SORTED_UNION_OF_TWO_SETS_TOP_DEFINES_SVH

// same-cycle implication, off while reset is asserted
`define SOSU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off while reset is asserted
`define SOSU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/sosu_pkg.sv
// types and constants of the sorted set union block
package sosu_pkg;

	localparam int VALUE_W  = 32;
	localparam int POS_W    = 5;
	localparam int COUNT_W  = 6;
	localparam int WIDE_W   = 7;
	localparam int MAX_OUT  = 32;
	localparam int COUNT_MAX = 63;

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [1:0]                command_t;
	typedef logic [POS_W-1:0]          pos_t;
	typedef logic [COUNT_W-1:0]        count_t;

	localparam command_t CMD_LOAD_A = 2'd0;
	localparam command_t CMD_LOAD_B = 2'd1;
	localparam command_t CMD_FINISH = 2'd2;

	typedef struct packed {
		logic insert;
		logic shift;
		logic clear;
	} cell_ctrl_t;

endpackage

>>> hdl/sosu_if.sv
// valid/ready channels for load/finish commands and for results
interface sosu_in_if;
	import sosu_pkg::*;

	logic     valid;
	logic     ready;
	command_t command;
	value_t   value;

	modport source (output valid, output command, output value, input ready);
	modport sink (input valid, input command, input value, output ready);
endinterface

interface sosu_out_if;
	import sosu_pkg::*;

	logic   valid;
	logic   ready;
	value_t result_value;
	pos_t   position;
	logic   last;
	count_t distinct_count;
	logic   overflow;

	modport source (output valid, output result_value, output position, output last,
		output distinct_count, output overflow, input ready);
	modport sink (input valid, input result_value, input position, input last,
		input distinct_count, input overflow, output ready);
endinterface

>>> hdl/sosu_cell.sv
// one cell of the sorted insertion chain
module sosu_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  sosu_pkg::cell_ctrl_t ctrl,
	input  sosu_pkg::value_t    new_val,
	input  logic                prev_goes,
	input  sosu_pkg::value_t    prev_val,
	input  logic                prev_vld,
	input  sosu_pkg::value_t    next_val,
	input  logic                next_vld,
	output logic                goes,
	output logic                eq,
	output sosu_pkg::value_t    val,
	output logic                vld
);
	import sosu_pkg::*;

	value_t val_q;
	logic   vld_q;

	// new value belongs here or further up the chain
	assign goes = !vld_q || (new_val < val_q);
	assign eq   = vld_q && (new_val == val_q);
	assign val  = val_q;
	assign vld  = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctrl.clear) begin
			vld_q <= 1'b0;
		end else if (ctrl.shift) begin
			vld_q <= next_vld;
		end else if (ctrl.insert && goes) begin
			vld_q <= prev_goes ? prev_vld : 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			val_q <= next_val;
		end else if (ctrl.insert && goes) begin
			val_q <= prev_goes ? prev_val : new_val;
		end
	end

endmodule

>>> hdl/sosu_chain.sv
// row of cells kept in ascending order, shifts out toward cell zero
module sosu_chain #(
	parameter int CELLS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sosu_pkg::cell_ctrl_t ctrl,
	input  sosu_pkg::value_t     new_val,
	output logic                 any_eq,
	output sosu_pkg::value_t     head_val
);
	import sosu_pkg::*;

	value_t           val   [CELLS];
	logic [CELLS-1:0] vld;
	logic [CELLS-1:0] goes;
	logic [CELLS-1:0] eq;

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		logic   p_goes;
		logic   p_vld;
		value_t p_val;
		logic   n_vld;
		value_t n_val;

		if (i == 0) begin : g_first
			assign p_goes = 1'b0;
			assign p_vld  = 1'b0;
			assign p_val  = '0;
		end else begin : g_mid
			assign p_goes = goes[i-1];
			assign p_vld  = vld[i-1];
			assign p_val  = val[i-1];
		end

		if (i == CELLS - 1) begin : g_end
			assign n_vld = 1'b0;
			assign n_val = '0;
		end else begin : g_inner
			assign n_vld = vld[i+1];
			assign n_val = val[i+1];
		end

		sosu_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.new_val   (new_val),
			.prev_goes (p_goes),
			.prev_val  (p_val),
			.prev_vld  (p_vld),
			.next_val  (n_val),
			.next_vld  (n_vld),
			.goes      (goes[i]),
			.eq        (eq[i]),
			.val       (val[i]),
			.vld       (vld[i])
		);
	end

	assign any_eq   = |eq;
	assign head_val = val[0];

endmodule

>>> hdl/sorted_union_of_two_sets_top.sv
// loads: one transaction per cycle while no run is streaming, each inserted into the sorted chain as accepted
// finish: sets the busy flag, after which the chain head is registered in the output register,
// then one result per cycle while the sink takes them; input is held off until the last
// result has been loaded into the output register, while the chain shifts its head into the
// output register, one entry per step
// reset: chain, fill counts, overflow flag and output valid cleared asynchronously
module sorted_union_of_two_sets_top #(
	parameter int DEPTH = 16
) (
	input  logic   clk,
	input  logic   arst_n,
	sosu_in_if.sink    in_ch,
	sosu_out_if.source out_ch
);
	import sosu_pkg::*;

	localparam int CELLS  = 2 * DEPTH;
	localparam int FILL_W = $clog2(DEPTH + 1);
	localparam int CNT_W  = $clog2(CELLS + 1);

	logic              busy_q;
	logic [FILL_W-1:0] fill_a_q;
	logic [FILL_W-1:0] fill_b_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              dropped_q;
	pos_t              pos_q;

	logic   out_vld_q;
	value_t out_val_q;
	pos_t   out_pos_q;
	logic   out_last_q;
	count_t out_cnt_q;
	logic   out_ovf_q;

	logic          in_acc;
	logic          load_a;
	logic          load_b;
	logic          full_a;
	logic          full_b;
	logic          any_eq;
	value_t        head_val;
	logic          step;
	logic          last_now;
	logic [WIDE_W-1:0] cnt_wide;
	logic [WIDE_W-1:0] emit_n;
	cell_ctrl_t    ctrl;

	assign in_ch.ready = !busy_q;
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign load_a      = in_acc && (in_ch.command == CMD_LOAD_A);
	assign load_b      = in_acc && (in_ch.command == CMD_LOAD_B);
	assign full_a      = (fill_a_q == FILL_W'(DEPTH));
	assign full_b      = (fill_b_q == FILL_W'(DEPTH));

	assign cnt_wide = WIDE_W'(cnt_q);
	assign emit_n   = (cnt_wide > WIDE_W'(MAX_OUT)) ? WIDE_W'(MAX_OUT) : cnt_wide;
	assign step     = busy_q && (!out_vld_q || out_ch.ready);
	assign last_now = (cnt_q == '0) || ((WIDE_W'(pos_q) + WIDE_W'(1)) == emit_n);

	// a value already in the chain counts toward its set but is not stored twice
	assign ctrl.insert = ((load_a && !full_a) || (load_b && !full_b)) && !any_eq;
	assign ctrl.shift  = step;
	assign ctrl.clear  = step && last_now;

	sosu_chain #(
		.CELLS (CELLS)
	) u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.new_val  (in_ch.value),
		.any_eq   (any_eq),
		.head_val (head_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			fill_a_q  <= '0;
			fill_b_q  <= '0;
			cnt_q     <= '0;
			dropped_q <= 1'b0;
			pos_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (in_acc && (in_ch.command == CMD_FINISH)) begin
				busy_q <= 1'b1;
				pos_q  <= '0;
			end
			if (load_a) begin
				if (full_a) begin
					dropped_q <= 1'b1;
				end else begin
					fill_a_q <= fill_a_q + FILL_W'(1);
				end
			end
			if (load_b) begin
				if (full_b) begin
					dropped_q <= 1'b1;
				end else begin
					fill_b_q <= fill_b_q + FILL_W'(1);
				end
			end
			if (ctrl.insert) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (step) begin
				pos_q <= pos_q + POS_W'(1);
			end
			// end of run empties both sets
			if (ctrl.clear) begin
				busy_q    <= 1'b0;
				fill_a_q  <= '0;
				fill_b_q  <= '0;
				cnt_q     <= '0;
				dropped_q <= 1'b0;
			end
			if (step) begin
				out_vld_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_val_q  <= (cnt_q == '0) ? '0 : head_val;
			out_pos_q  <= pos_q;
			out_last_q <= last_now;
			out_cnt_q  <= (cnt_wide > WIDE_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
				: cnt_wide[COUNT_W-1:0];
			out_ovf_q  <= dropped_q;
		end
	end

	assign out_ch.valid          = out_vld_q;
	assign out_ch.result_value   = out_val_q;
	assign out_ch.position       = out_pos_q;
	assign out_ch.last           = out_last_q;
	assign out_ch.distinct_count = out_cnt_q;
	assign out_ch.overflow       = out_ovf_q;

endmodule

>>> hdl/sosu_checker.sv
// port-level checks of the sorted set union block, bound to the top level
`include "sorted_union_of_two_sets_top_defines.svh"

module sosu_port_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input sosu_pkg::value_t out_value,
	input sosu_pkg::pos_t   out_position,
	input logic             out_last,
	input sosu_pkg::count_t out_count
);
	import sosu_pkg::*;

	// a stalled result holds
	`SOSU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value) && $stable(out_position), "stalled result changed")

	// no new command while a run is still being streamed
	`SOSU_ASSERT_NOW(a_run_blocks_in, out_valid && !out_last, !in_ready, "input taken mid run")

	// empty run is a single zero result
	`SOSU_ASSERT_NOW(a_empty_run, out_valid && (out_count == '0), out_last && (out_position == '0) && (out_value == '0), "bad empty run result")

	// a result that is not last always has more distinct values behind it
	`SOSU_ASSERT_NOW(a_more_left, out_valid && !out_last, (COUNT_W'(out_position) + COUNT_W'(1)) < out_count, "run ended early")

endmodule

bind sorted_union_of_two_sets_top sosu_port_checker u_sosu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.out_value    (out_ch.result_value),
	.out_position (out_ch.position),
	.out_last     (out_ch.last),
	.out_count    (out_ch.distinct_count)
);

>>> bench/sosu_checker.sv
// checker for the sorted set union block: tracks both sets, predicts each run and compares it
module sosu_checker #(
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	sosu_in_if   in_ch,
	sosu_out_if  out_ch,
	output int   fail_count,
	output int   results_due
);
	import sosu_pkg::*;

	typedef struct packed {
		value_t value;
		pos_t   position;
		logic   last;
		count_t total;
		logic   overflow;
	} union_entry_t;

	union_entry_t union_q[$];
	value_t set_a [DEPTH];
	value_t set_b [DEPTH];
	int fill_a;
	int fill_b;
	logic dropped;

	initial fail_count = 0;

	task automatic report(input string msg);
		$display("checker: %0t %s", $time, msg);
		fail_count++;
	endtask

	// gather both sets, sort ascending as signed, squeeze out repeats, queue the run
	task automatic predict_union();
		value_t merged[$];
		value_t uniq[$];
		value_t key;
		union_entry_t entry;
		int j;
		int emit;
		for (int i = 0; i < fill_a; i++)
			merged.push_back(set_a[i]);
		for (int i = 0; i < fill_b; i++)
			merged.push_back(set_b[i]);
		for (int i = 1; i < merged.size(); i++) begin
			key = merged[i];
			j = i;
			while (j > 0 && merged[j-1] > key) begin
				merged[j] = merged[j-1];
				j--;
			end
			merged[j] = key;
		end
		for (int i = 0; i < merged.size(); i++) begin
			if (uniq.size() == 0 || merged[i] != uniq[uniq.size()-1])
				uniq.push_back(merged[i]);
		end
		entry.overflow = dropped;
		entry.total = (uniq.size() > COUNT_MAX) ? count_t'(COUNT_MAX) : count_t'(uniq.size());
		if (uniq.size() == 0) begin
			entry.value = '0;
			entry.position = '0;
			entry.last = 1'b1;
			union_q.push_back(entry);
		end else begin
			emit = (uniq.size() > MAX_OUT) ? MAX_OUT : uniq.size();
			for (int k = 0; k < emit; k++) begin
				entry.value = uniq[k];
				entry.position = pos_t'(k);
				entry.last = (k + 1 == emit);
				union_q.push_back(entry);
			end
		end
		fill_a = 0;
		fill_b = 0;
		dropped = 1'b0;
	endtask

	task automatic check_result();
		union_entry_t want;
		if (union_q.size() == 0) begin
			report($sformatf("result %0d with nothing expected", out_ch.result_value));
		end else begin
			want = union_q.pop_front();
			if (out_ch.result_value !== want.value)
				report($sformatf("result_value got %0d want %0d", out_ch.result_value, want.value));
			if (out_ch.position !== want.position)
				report($sformatf("position got %0d want %0d", out_ch.position, want.position));
			if (out_ch.last !== want.last)
				report($sformatf("last got %b want %b", out_ch.last, want.last));
			if (out_ch.distinct_count !== want.total)
				report($sformatf("distinct_count got %0d want %0d", out_ch.distinct_count,
					want.total));
			if (out_ch.overflow !== want.overflow)
				report($sformatf("overflow got %b want %b", out_ch.overflow, want.overflow));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			union_q.delete();
			fill_a = 0;
			fill_b = 0;
			dropped = 1'b0;
			results_due = 0;
		end else begin
			if (out_ch.valid && out_ch.ready)
				check_result();
			if (in_ch.valid && in_ch.ready) begin
				case (in_ch.command)
					CMD_LOAD_A: begin
						if (fill_a < DEPTH) begin
							set_a[fill_a] = in_ch.value;
							fill_a++;
						end else begin
							dropped = 1'b1;
						end
					end
					CMD_LOAD_B: begin
						if (fill_b < DEPTH) begin
							set_b[fill_b] = in_ch.value;
							fill_b++;
						end else begin
							dropped = 1'b1;
						end
					end
					CMD_FINISH: begin
						predict_union();
					end
					default: begin
					end
				endcase
			end
			results_due = union_q.size();
		end
	end

endmodule

>>> bench/tb.sv
// testbench top: clock, reset, load and finish stimulus, result sink and verdict
module tb;
	import sosu_pkg::*;

	localparam int DEPTH = 16;
	localparam int ITEM_TARGET = 350;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int LONG_HOLD = 300;
	localparam int DRAIN_CYCLES = 20;
	localparam command_t CMD_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int fail_count;
	int results_due;
	int cycles = 0;
	int items_sent = 0;
	bit sender_fast = 1'b0;
	bit sink_hold_req = 1'b0;

	sosu_in_if in_ch ();
	sosu_out_if out_ch ();

	sorted_union_of_two_sets_top #(.DEPTH(DEPTH)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	sosu_checker #(.DEPTH(DEPTH)) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.fail_count(fail_count),
		.results_due(results_due)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic value_t pick_value();
		case ($urandom_range(0, 5))
			0: return value_t'(int'($urandom_range(0, 8)) - 4);
			1: return 32'sh7FFF_FFFF;
			2: return 32'sh8000_0000;
			default: return value_t'($urandom);
		endcase
	endfunction

	// one transaction on the command channel, after a random gap unless in a burst
	task automatic send(input command_t cmd, input value_t val);
		int gap;
		gap = sender_fast ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= cmd;
		in_ch.value <= val;
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
		if (cmd != CMD_UNUSED)
			items_sent++;
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		while (results_due != 0)
			@(negedge clk);
	endtask

	// narrow values give many repeats and overflow one set now and then
	task automatic load_run(input int n, input bit wide);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 19) == 0)
				send(CMD_UNUSED, value_t'($urandom));
			send($urandom_range(0, 1) ? CMD_LOAD_B : CMD_LOAD_A,
				wide ? pick_value() : value_t'($urandom_range(0, 5)));
		end
	endtask

	initial begin : result_sink
		int gap_left;
		int hold_left;
		bit fast;
		bit took;
		gap_left = 0;
		hold_left = 0;
		fast = 1'b0;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			took = out_ch.valid && out_ch.ready;
			@(negedge clk);
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (took) begin
				if ($urandom_range(0, 15) == 0)
					fast = !fast;
				gap_left = fast ? 0 : $urandom_range(0, 19);
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	initial begin : stimulus
		int kind;
		in_ch.valid = 1'b0;
		in_ch.command = CMD_LOAD_A;
		in_ch.value = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// finish with both sets empty
		send(CMD_FINISH, value_t'($urandom));
		// extremes, repeats across the two sets
		send(CMD_LOAD_A, 32'sh7FFF_FFFF);
		send(CMD_LOAD_A, 32'sh8000_0000);
		send(CMD_LOAD_A, 32'sh0000_0000);
		send(CMD_LOAD_A, -32'sd1);
		send(CMD_LOAD_B, -32'sd1);
		send(CMD_LOAD_B, 32'sd1);
		send(CMD_LOAD_B, 32'sh8000_0000);
		send(CMD_FINISH, 32'sh7FFF_FFFF);
		// unused code changes nothing
		send(CMD_UNUSED, 32'sd42);
		send(CMD_FINISH, 32'sh8000_0000);
		// repeats within one set
		send(CMD_LOAD_A, 32'sd5);
		send(CMD_LOAD_A, 32'sd5);
		send(CMD_LOAD_B, 32'sd5);
		send(CMD_FINISH, '0);
		// only set b loaded
		send(CMD_LOAD_B, 32'sd3);
		send(CMD_FINISH, -32'sd1);

		// sender pauses for the sink, then the sink stalls while both sets fill up
		wait_drained();
		sink_hold_req = 1'b1;
		sender_fast = 1'b1;
		for (int i = 0; i < DEPTH; i++)
			send(CMD_LOAD_A, value_t'(i * 7 - 50));
		for (int i = 0; i < DEPTH + 2; i++)
			send(CMD_LOAD_B, value_t'($urandom));
		send(CMD_FINISH, '0);
		load_run(4, 1'b1);
		send(CMD_FINISH, '0);
		send(CMD_UNUSED, value_t'($urandom));
		send(CMD_FINISH, '0);
		wait_drained();

		while (items_sent < ITEM_TARGET) begin
			sender_fast = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 9);
			if (kind <= 5) begin
				load_run($urandom_range(0, 12), 1'b1);
				send(CMD_FINISH, value_t'($urandom));
			end else if (kind <= 7) begin
				load_run($urandom_range(8, 24), 1'b0);
				send(CMD_FINISH, value_t'($urandom));
			end else if (kind == 8) begin
				// both sets full of wide values, sometimes past the depth
				for (int i = 0; i < DEPTH; i++)
					send(CMD_LOAD_A, value_t'($urandom));
				for (int i = 0; i < DEPTH; i++)
					send(CMD_LOAD_B, value_t'($urandom));
				load_run($urandom_range(0, 2), 1'b1);
				send(CMD_FINISH, value_t'($urandom));
			end else begin
				// broken sequence: any command codes in any order
				repeat ($urandom_range(1, 6))
					send(command_t'($urandom_range(0, 3)), pick_value());
			end
		end
		send(CMD_FINISH, value_t'($urandom));

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hdl
hdl/sosu_pkg.sv
hdl/sosu_if.sv
hdl/sosu_cell.sv
hdl/sosu_chain.sv
hdl/sorted_union_of_two_sets_top.sv
hdl/sosu_checker.sv
bench/sosu_checker.sv
bench/tb.sv
